/* rtl/core/smnm_pkg.sv */
package smnm_pkg;

   localparam int FFT_SIZE_DEF       = 4096;
   localparam int PEAKS_DEF          = 5;
   localparam int TEMPLATE_DEPTH_DEF = 128;

   localparam int CFG_W      = 8;
   localparam int SLOT_W     = 7;
   localparam int TBIN_W     = 12;
   localparam int MAG_W      = 16;
   localparam int PEAK_NUM_W = 3;
   localparam int NOTE_W     = 7;
   localparam int PBIN_W     = 12;

   localparam logic [CFG_W-1:0] MARGIN_RESET = 8'd10;
   localparam logic [CFG_W-1:0] COUNT_RESET  = 8'd127;

   localparam logic CSR_SEARCH_MARGIN  = 1'b0;
   localparam logic CSR_TEMPLATE_COUNT = 1'b1;

   localparam logic OP_TEMPLATE = 1'b0;
   localparam logic OP_BIN      = 1'b1;

   typedef struct packed {
      logic              we;
      logic [SLOT_W-1:0] slot;
      logic [TBIN_W-1:0] bin;
   } tpl_write_type;

   typedef struct packed {
      logic              done;
      logic [NOTE_W-1:0] note;
   } match_status_type;

endpackage

/* rtl/core/smnm_ram.sv */
module smnm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2049
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/core/smnm_match.sv */
module smnm_match
   import smnm_pkg::*;
#(
   parameter int TEMPLATE_DEPTH = TEMPLATE_DEPTH_DEF,
   parameter int PEAK_W         = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  tpl_write_type     tpl_wr,
   input  logic              start,
   input  logic [PEAK_W-1:0] peak,
   input  logic [CFG_W-1:0]  count,
   output match_status_type  status
);

   localparam int TPL_AW = $clog2(TEMPLATE_DEPTH);
   localparam int CNT_W  = $clog2(TEMPLATE_DEPTH + 1);
   localparam int XW     = (CNT_W > CFG_W) ? CNT_W : CFG_W;
   localparam int DW     = (TBIN_W > PEAK_W) ? TBIN_W : PEAK_W;

   typedef enum logic {M_IDLE, M_RUN} mstate_type;

   mstate_type        state_ff, state_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [CNT_W-1:0]  issue_ff, issue_in;
   logic              rv_ff, rv_in;
   logic [TPL_AW-1:0] ridx_ff, ridx_in;
   logic [DW-1:0]     best_ff, best_in;
   logic [TPL_AW-1:0] winner_ff, winner_in;
   logic [PEAK_W-1:0] peak_ff, peak_in;
   logic              done_ff, done_in;

   logic [TPL_AW-1:0]    ram_addr;
   logic                 ram_we;
   logic [TBIN_W-1:0]    ram_rdata;
   logic [TPL_AW+6:0]    slot_x;
   logic [XW-1:0]        cnt_x;
   logic [XW-1:0]        n_x;
   logic [DW:0]          diff;
   logic [DW-1:0]        distance;
   logic [TPL_AW+6:0]    winner_x;
   logic                 more;

   assign slot_x   = {{TPL_AW{1'b0}}, tpl_wr.slot};
   assign cnt_x    = XW'(count);
   assign more     = (issue_ff < n_ff);
   assign diff     = (DW+1)'(ram_rdata) - (DW+1)'(peak_ff);
   assign distance = diff[DW] ? DW'(-diff) : diff[DW-1:0];
   assign winner_x = {{SLOT_W{1'b0}}, winner_ff};

   always_comb begin
      if (cnt_x == '0) begin
         n_x = XW'(1);
      end else if (cnt_x > XW'(TEMPLATE_DEPTH)) begin
         n_x = XW'(TEMPLATE_DEPTH);
      end else begin
         n_x = cnt_x;
      end
   end

   always_comb begin
      ram_we   = tpl_wr.we && (slot_x < (TPL_AW+7)'(TEMPLATE_DEPTH)) && (state_ff == M_IDLE);
      ram_addr = slot_x[TPL_AW-1:0];
      if (state_ff == M_RUN) begin
         ram_addr = issue_ff[TPL_AW-1:0];
      end
   end

   smnm_ram #(
      .WIDTH (TBIN_W),
      .DEPTH (TEMPLATE_DEPTH)
   ) u_tpl_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (tpl_wr.bin),
      .rdata (ram_rdata)
   );

   always_comb begin
      state_in  = state_ff;
      n_in      = n_ff;
      issue_in  = issue_ff;
      rv_in     = 1'b0;
      ridx_in   = ridx_ff;
      best_in   = best_ff;
      winner_in = winner_ff;
      peak_in   = peak_ff;
      done_in   = 1'b0;
      case (state_ff)
         M_IDLE: begin
            if (start) begin
               n_in     = n_x[CNT_W-1:0];
               issue_in = '0;
               peak_in  = peak;
               state_in = M_RUN;
            end
         end
         M_RUN: begin
            if (more) begin
               issue_in = issue_ff + 1'b1;
               rv_in    = 1'b1;
               ridx_in  = issue_ff[TPL_AW-1:0];
            end
            if (rv_ff) begin
               if ((ridx_ff == '0) || (distance < best_ff)) begin
                  best_in   = distance;
                  winner_in = ridx_ff;
               end
            end
            if (!more && !rv_ff) begin
               done_in  = 1'b1;
               state_in = M_IDLE;
            end
         end
         default: state_in = M_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         rv_ff    <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
         done_ff  <= done_in;
      end
      n_ff      <= n_in;
      issue_ff  <= issue_in;
      ridx_ff   <= ridx_in;
      best_ff   <= best_in;
      winner_ff <= winner_in;
      peak_ff   <= peak_in;
   end

   assign status.done = done_ff;
   assign status.note = winner_x[NOTE_W-1:0];

endmodule

/* rtl/core/spectral_multi_peak_note_matcher_top.sv */
// Spectral peak picker with nearest-note match. op 0 items load a note
// template (one peak bin per slot); op 1 items append one magnitude bin to the
// frame, one item per cycle. The item marked last_bin starts PEAKS_PER_FRAME
// rounds, each giving one result: the first largest bin, the template nearest
// to it (lowest slot on ties), then a downhill walk out from peak -/+ margin and
// a zeroing of the walked range. A round scans the single-port spectrum
// memory, then the template memory, emits its result once the output register
// is free, then walks one bin per step and clears the walked bins one at a
// time. A full frame holds at most 2049 bins by default. No item is taken
// while rounds run; the last result may wait in the output register while new
// items are accepted.
module spectral_multi_peak_note_matcher_top
   import smnm_pkg::*;
#(
   parameter int FFT_SIZE        = FFT_SIZE_DEF,
   parameter int PEAKS_PER_FRAME = PEAKS_DEF,
   parameter int TEMPLATE_DEPTH  = TEMPLATE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CFG_W-1:0]      csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_op,
   input  logic [SLOT_W-1:0]     req_template_slot,
   input  logic [TBIN_W-1:0]     req_template_bin,
   input  logic [MAG_W-1:0]      req_magnitude,
   input  logic                  req_last_bin,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [PEAK_NUM_W-1:0] rsp_peak_number,
   output logic [NOTE_W-1:0]     rsp_note,
   output logic [PBIN_W-1:0]     rsp_peak_bin,
   output logic                  rsp_last
);

   localparam int BIN_COUNT = FFT_SIZE / 2 + 1;
   localparam int BIN_AW    = $clog2(BIN_COUNT);
   localparam int POS_W     = $clog2(BIN_COUNT + 1);
   localparam int SW        = ((POS_W > CFG_W) ? POS_W : CFG_W) + 2;
   localparam int RND_W     = (PEAKS_PER_FRAME > 1) ? $clog2(PEAKS_PER_FRAME) : 1;

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN, S_MATCH, S_EMIT, S_LO_TEST, S_LO_CMP, S_HI_TEST, S_HI_CMP, S_CLEAR
   } state_type;

   state_type                state_ff, state_in;
   logic [CFG_W-1:0]         margin_ff, margin_in;
   logic [CFG_W-1:0]         tcount_ff, tcount_in;
   logic [POS_W-1:0]         pos_ff, pos_in;
   logic [POS_W-1:0]         len_ff, len_in;
   logic [RND_W-1:0]         round_ff, round_in;
   logic [POS_W-1:0]         scan_ff, scan_in;
   logic                     sv_ff, sv_in;
   logic [BIN_AW-1:0]        sidx_ff, sidx_in;
   logic [MAG_W-1:0]         top_ff, top_in;
   logic [BIN_AW-1:0]        best_ff, best_in;
   logic [MAG_W-1:0]         level_ff, level_in;
   logic signed [SW-1:0]     lo_ff, lo_in;
   logic signed [SW-1:0]     hi_ff, hi_in;
   logic [BIN_AW-1:0]        clr_ff, clr_in;
   logic [BIN_AW-1:0]        clr_end_ff, clr_end_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [PEAK_NUM_W-1:0]    rsp_peak_number_ff, rsp_peak_number_in;
   logic [NOTE_W-1:0]        rsp_note_ff, rsp_note_in;
   logic [PBIN_W-1:0]        rsp_peak_bin_ff, rsp_peak_bin_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic                     spec_we;
   logic [BIN_AW-1:0]        spec_addr;
   logic [MAG_W-1:0]         spec_wdata;
   logic [MAG_W-1:0]         spec_rdata;

   tpl_write_type            tpl_wr;
   match_status_type         mstat;
   logic                     match_start;

   logic                     req_fire;
   logic                     pos_room;
   logic                     scan_more;
   logic                     last_round;
   logic signed [SW-1:0]     len_s;
   logic signed [SW-1:0]     peak_s;
   logic signed [SW-1:0]     margin_s;
   logic [POS_W-1:0]         len_m1;
   logic [BIN_AW-1:0]        clr_start;
   logic [BIN_AW-1:0]        clr_stop;
   logic [RND_W+PEAK_NUM_W-1:0] round_x;
   logic [BIN_AW+PBIN_W-1:0]    best_x;

   assign req_ready  = (state_ff == S_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign pos_room   = (pos_ff < POS_W'(BIN_COUNT));
   assign scan_more  = (scan_ff < len_ff);
   assign last_round = (round_ff == RND_W'(PEAKS_PER_FRAME - 1));
   assign len_s      = {{(SW-POS_W){1'b0}}, len_ff};
   assign peak_s     = {{(SW-BIN_AW){1'b0}}, best_ff};
   assign margin_s   = {{(SW-CFG_W){1'b0}}, margin_ff};
   assign len_m1     = len_ff - 1'b1;
   assign clr_start  = (lo_ff < 0) ? '0 : lo_ff[BIN_AW-1:0];
   assign clr_stop   = (hi_ff >= len_s) ? len_m1[BIN_AW-1:0] : hi_ff[BIN_AW-1:0];
   assign round_x    = {{PEAK_NUM_W{1'b0}}, round_ff};
   assign best_x     = {{PBIN_W{1'b0}}, best_ff};

   assign tpl_wr.we   = req_fire && (req_op == OP_TEMPLATE);
   assign tpl_wr.slot = req_template_slot;
   assign tpl_wr.bin  = req_template_bin;

   assign match_start = (state_ff == S_SCAN) && !scan_more && !sv_ff;

   smnm_ram #(
      .WIDTH (MAG_W),
      .DEPTH (BIN_COUNT)
   ) u_spec_ram (
      .clock (clock),
      .we    (spec_we),
      .addr  (spec_addr),
      .wdata (spec_wdata),
      .rdata (spec_rdata)
   );

   smnm_match #(
      .TEMPLATE_DEPTH (TEMPLATE_DEPTH),
      .PEAK_W         (BIN_AW)
   ) u_match (
      .clock  (clock),
      .reset  (reset),
      .tpl_wr (tpl_wr),
      .start  (match_start),
      .peak   (best_ff),
      .count  (tcount_ff),
      .status (mstat)
   );

   always_comb begin
      state_in           = state_ff;
      margin_in          = margin_ff;
      tcount_in          = tcount_ff;
      pos_in             = pos_ff;
      len_in             = len_ff;
      round_in           = round_ff;
      scan_in            = scan_ff;
      sv_in              = 1'b0;
      sidx_in            = sidx_ff;
      top_in             = top_ff;
      best_in            = best_ff;
      level_in           = level_ff;
      lo_in              = lo_ff;
      hi_in              = hi_ff;
      clr_in             = clr_ff;
      clr_end_in         = clr_end_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_ready;
      rsp_peak_number_in = rsp_peak_number_ff;
      rsp_note_in        = rsp_note_ff;
      rsp_peak_bin_in    = rsp_peak_bin_ff;
      rsp_last_in        = rsp_last_ff;
      spec_we            = 1'b0;
      spec_addr          = pos_ff[BIN_AW-1:0];
      spec_wdata         = req_magnitude;

      if (csr_we) begin
         case (csr_index)
            CSR_SEARCH_MARGIN:  margin_in = csr_wdata;
            CSR_TEMPLATE_COUNT: tcount_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire && (req_op == OP_BIN)) begin
               spec_we = pos_room;
               if (pos_room) begin
                  pos_in = pos_ff + 1'b1;
               end
               if (req_last_bin) begin
                  len_in   = pos_room ? (pos_ff + 1'b1) : pos_ff;
                  pos_in   = '0;
                  round_in = '0;
                  scan_in  = '0;
                  top_in   = '0;
                  best_in  = '0;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            spec_addr = scan_ff[BIN_AW-1:0];
            if (scan_more) begin
               scan_in = scan_ff + 1'b1;
               sv_in   = 1'b1;
               sidx_in = scan_ff[BIN_AW-1:0];
            end
            if (sv_ff && (spec_rdata > top_ff)) begin
               top_in  = spec_rdata;
               best_in = sidx_ff;
            end
            if (match_start) begin
               state_in = S_MATCH;
            end
         end
         S_MATCH: begin
            if (mstat.done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in       = 1'b1;
               rsp_peak_number_in = round_x[PEAK_NUM_W-1:0];
               rsp_note_in        = mstat.note;
               rsp_peak_bin_in    = best_x[PBIN_W-1:0];
               rsp_last_in        = last_round;
               lo_in              = peak_s - margin_s;
               level_in           = top_ff;
               state_in           = S_LO_TEST;
            end
         end
         S_LO_TEST: begin
            spec_addr = lo_ff[BIN_AW-1:0];
            if ((lo_ff > 0) && (lo_ff < len_s)) begin
               state_in = S_LO_CMP;
            end else begin
               hi_in    = peak_s + margin_s;
               level_in = top_ff;
               state_in = S_HI_TEST;
            end
         end
         S_LO_CMP: begin
            if (spec_rdata <= level_ff) begin
               level_in = spec_rdata;
               lo_in    = lo_ff - 1'b1;
               state_in = S_LO_TEST;
            end else begin
               hi_in    = peak_s + margin_s;
               level_in = top_ff;
               state_in = S_HI_TEST;
            end
         end
         S_HI_TEST: begin
            spec_addr = hi_ff[BIN_AW-1:0];
            if (hi_ff < len_s) begin
               state_in = S_HI_CMP;
            end else begin
               clr_in     = clr_start;
               clr_end_in = clr_stop;
               state_in   = S_CLEAR;
            end
         end
         S_HI_CMP: begin
            if (spec_rdata <= level_ff) begin
               level_in = spec_rdata;
               hi_in    = hi_ff + 1'b1;
               state_in = S_HI_TEST;
            end else begin
               clr_in     = clr_start;
               clr_end_in = clr_stop;
               state_in   = S_CLEAR;
            end
         end
         S_CLEAR: begin
            spec_we    = 1'b1;
            spec_addr  = clr_ff;
            spec_wdata = '0;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == clr_end_ff) begin
               if (last_round) begin
                  state_in = S_IDLE;
               end else begin
                  round_in = round_ff + 1'b1;
                  scan_in  = '0;
                  top_in   = '0;
                  best_in  = '0;
                  state_in = S_SCAN;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         margin_ff    <= MARGIN_RESET;
         tcount_ff    <= COUNT_RESET;
         pos_ff       <= '0;
         sv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         margin_ff    <= margin_in;
         tcount_ff    <= tcount_in;
         pos_ff       <= pos_in;
         sv_ff        <= sv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      len_ff             <= len_in;
      round_ff           <= round_in;
      scan_ff            <= scan_in;
      sidx_ff            <= sidx_in;
      top_ff             <= top_in;
      best_ff            <= best_in;
      level_ff           <= level_in;
      lo_ff              <= lo_in;
      hi_ff              <= hi_in;
      clr_ff             <= clr_in;
      clr_end_ff         <= clr_end_in;
      rsp_peak_number_ff <= rsp_peak_number_in;
      rsp_note_ff        <= rsp_note_in;
      rsp_peak_bin_ff    <= rsp_peak_bin_in;
      rsp_last_ff        <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_peak_number = rsp_peak_number_ff;
   assign rsp_note        = rsp_note_ff;
   assign rsp_peak_bin    = rsp_peak_bin_ff;
   assign rsp_last        = rsp_last_ff;

endmodule
